FILE: sv/ddot_pkg.sv
// shared types and constants for the digest dedup offset table
package ddot_pkg;

  localparam int unsigned DIG_W  = 64;
  localparam int unsigned OFF_W  = 32;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned SLOT_N = 64;

  // search token walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIG_W-1:0]  dig_hi;
    logic [DIG_W-1:0]  dig_lo;
    logic [OFF_W-1:0]  off;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  // append write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [DIG_W-1:0] dig_hi;
    logic [DIG_W-1:0] dig_lo;
    logic [OFF_W-1:0] off;
  } wr_t;

endpackage

FILE: sv/ddot_cell.sv
// one table entry: stores digest and offset, checks the passing search token
module ddot_cell import ddot_pkg::*; #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned K       = 0,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] used_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  wr_t              wr_i,
  input  logic [IDX_W-1:0] wr_idx_i
);

  localparam logic [SLOT_W-1:0] MySlot = SLOT_W'(K % SLOT_N);

  logic [DIG_W-1:0] hi_q;
  logic [DIG_W-1:0] lo_q;
  logic [OFF_W-1:0] off_q;
  logic             match;
  tok_t             tok_d;
  tok_t             tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_idx_i == IDX_W'(K))) begin
      hi_q  <= wr_i.dig_hi;
      lo_q  <= wr_i.dig_lo;
      off_q <= wr_i.off;
    end
  end

  // only filled entries take part
  assign match = tok_i.valid && !tok_i.found && (CNT_W'(K) < used_i) &&
                 (hi_q == tok_i.dig_hi) && (lo_q == tok_i.dig_lo);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.found = 1'b1;
      tok_d.off   = off_q;
      tok_d.slot  = MySlot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/digest_dedup_offset_table.sv
// top level: lookup-or-insert digest table built as a chain of entry cells
//
// channel   direction  handshake                     payload
// command   in         start_i & !busy_o             digest_high_i, digest_low_i, block_length_i
// result    out        result_valid_o, one cycle     block_offset_o, hit_o, slot_o, table_full_o
// config    in         cfg_valid_i & cfg_ready_o     cfg_data_i (base offset)
//
// a command's search token moves one cell per cycle through each cell's register, and
// its arrival at the chain's end loads the result register, which raises the strobe;
// busy drops in the strobe cycle, so a new command can be taken at the edge that ends
// it, and only one command is in the chain at a time.
// the append into the free cell happens at the edge the result register loads.
// reset clears the fill count, the running offset, the handshake state and the cell tokens only.
// the receiver cannot stall; cfg_ready_o is always high.
module digest_dedup_offset_table import ddot_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [DIG_W-1:0]  digest_high_i,
  input  logic [DIG_W-1:0]  digest_low_i,
  input  logic [OFF_W-1:0]  block_length_i,
  output logic              result_valid_o,
  output logic [OFF_W-1:0]  block_offset_o,
  output logic              hit_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              table_full_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [OFF_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] Full = CNT_W'(ENTRIES);

  tok_t             chain [ENTRIES+1];
  tok_t             tail;
  wr_t              wr;
  logic             accept;
  logic             done;
  logic             full;
  logic             busy_d, busy_q;
  logic             rvalid_d, rvalid_q;
  logic [CNT_W-1:0] used_d, used_q;
  logic [OFF_W-1:0] run_d, run_q;
  logic [OFF_W-1:0] len_q;
  logic [OFF_W-1:0] off_d, off_q;
  logic             hit_d, hit_q;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic             tfull_d, tfull_q;

  assign accept      = start_i && !busy_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    chain[0].valid  = accept;
    chain[0].found  = 1'b0;
    chain[0].dig_hi = digest_high_i;
    chain[0].dig_lo = digest_low_i;
    chain[0].off    = '0;
    chain[0].slot   = '0;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ddot_cell #(
      .ENTRIES (ENTRIES),
      .K       (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .used_i   (used_q),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1]),
      .wr_i     (wr),
      .wr_idx_i (used_q[IDX_W-1:0])
    );
  end

  assign tail = chain[ENTRIES];
  assign done = tail.valid;
  assign full = (used_q == Full);

  always_comb begin
    wr.en     = done && !tail.found && !full;
    wr.dig_hi = tail.dig_hi;
    wr.dig_lo = tail.dig_lo;
    wr.off    = run_q;
  end

  always_comb begin
    busy_d   = busy_q;
    rvalid_d = done;
    used_d   = used_q;
    run_d    = run_q;
    off_d    = off_q;
    hit_d    = hit_q;
    slot_d   = slot_q;
    tfull_d  = tfull_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (done) begin
      busy_d = 1'b0;
      if (tail.found) begin
        off_d   = tail.off;
        hit_d   = 1'b1;
        slot_d  = tail.slot;
        tfull_d = 1'b0;
      end else if (full) begin
        off_d   = '0;
        hit_d   = 1'b0;
        slot_d  = '0;
        tfull_d = 1'b1;
      end else begin
        off_d   = run_q;
        hit_d   = 1'b0;
        slot_d  = SLOT_W'(used_q);
        tfull_d = 1'b0;
        used_d  = used_q + CNT_W'(1);
        run_d   = run_q + len_q;
      end
    end
    // base offset write reloads the running offset
    if (cfg_valid_i) begin
      run_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rvalid_q <= 1'b0;
      used_q   <= '0;
      run_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      rvalid_q <= rvalid_d;
      used_q   <= used_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q <= block_length_i;
    end
    off_q   <= off_d;
    hit_q   <= hit_d;
    slot_q  <= slot_d;
    tfull_q <= tfull_d;
  end

  assign busy_o         = busy_q;
  assign result_valid_o = rvalid_q;
  assign block_offset_o = off_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign table_full_o   = tfull_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |->
      (!hit_o && (block_offset_o == '0) && (slot_o == '0)))
    else $error("table full result carries data");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Full)
    else $error("fill count beyond table depth");

endmodule

FILE: dv/digest_dedup_offset_table_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the digest dedup offset table
module digest_dedup_offset_table_test;
  import ddot_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1140;
  localparam int unsigned PHASE_ITEMS  = 190;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } answer_t;

  // mirror of the table contents plus the answers still owed by the block
  class dedup_tracker;
    logic [DIG_W-1:0] known_hi[$];
    logic [DIG_W-1:0] known_lo[$];
    logic [OFF_W-1:0] known_off[$];
    logic [OFF_W-1:0] next_offset;
    answer_t          awaited[$];
    int unsigned      errors;

    function new();
      next_offset = '0;
      errors = 0;
    endfunction

    function void load_base(logic [OFF_W-1:0] value);
      next_offset = value;
    endfunction

    function void note_block(logic [DIG_W-1:0] hi, logic [DIG_W-1:0] lo,
                             logic [OFF_W-1:0] len);
      answer_t a;
      int      idx;
      idx = -1;
      foreach (known_hi[i]) begin
        if (idx < 0 && known_hi[i] == hi && known_lo[i] == lo) idx = i;
      end
      if (idx >= 0) begin
        a = '{off: known_off[idx], hit: 1'b1, slot: idx[SLOT_W-1:0], full: 1'b0};
      end else if (known_hi.size() >= TABLE_DEPTH) begin
        // miss with no free entry: nothing stored, offset untouched
        a = '{off: '0, hit: 1'b0, slot: '0, full: 1'b1};
      end else begin
        idx = known_hi.size();
        a = '{off: next_offset, hit: 1'b0, slot: idx[SLOT_W-1:0], full: 1'b0};
        known_hi.push_back(hi);
        known_lo.push_back(lo);
        known_off.push_back(next_offset);
        next_offset = next_offset + len;
      end
      awaited.push_back(a);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, offset %h", got.off));
        return;
      end
      want = awaited.pop_front();
      if (got.off !== want.off)
        report_mismatch($sformatf("block_offset %h, want %h", got.off, want.off));
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.full !== want.full)
        report_mismatch($sformatf("table_full %b, want %b", got.full, want.full));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [DIG_W-1:0]  dig_hi = '0;
  logic [DIG_W-1:0]  dig_lo = '0;
  logic [OFF_W-1:0]  blk_len = '0;
  logic              result_valid;
  logic [OFF_W-1:0]  block_offset;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              table_full;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [OFF_W-1:0]  cfg_data = '0;

  dedup_tracker tracker;

  digest_dedup_offset_table #(
    .ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .digest_high_i (dig_hi),
    .digest_low_i  (dig_lo),
    .block_length_i(blk_len),
    .result_valid_o(result_valid),
    .block_offset_o(block_offset),
    .hit_o         (hit),
    .slot_o        (slot),
    .table_full_o  (table_full),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && result_valid) begin
      tracker.check_answer('{off: block_offset, hit: hit, slot: slot, full: table_full});
    end
  end

  // holds start until the block takes the transaction
  task automatic send_block(logic [DIG_W-1:0] hi, logic [DIG_W-1:0] lo,
                            logic [OFF_W-1:0] len);
    start   <= 1'b1;
    dig_hi  <= hi;
    dig_lo  <= lo;
    blk_len <= len;
    do @(posedge clk); while (busy);
    tracker.note_block(hi, lo, len);
  endtask

  task automatic idle_for(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // only written once every answer is back and the block is quiet
  task automatic write_base(logic [OFF_W-1:0] value);
    start <= 1'b0;
    while (tracker.awaited.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.load_base(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DIG_W-1:0] hi;
    logic [DIG_W-1:0] lo;
    logic [DIG_W-1:0] prev_hi;
    logic [DIG_W-1:0] prev_lo;
    logic [OFF_W-1:0] len;
    logic [OFF_W-1:0] bases[6];
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      used;
    bit               quiet;

    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme digests, halves that differ in one word, zero and max
    // lengths, offset wrap, base reloads keeping the stored entries
    send_block('0, '0, '0);
    send_block('0, '0, 32'd5);
    send_block('1, '1, '1);
    send_block(64'd0, 64'd1, 32'd1);
    send_block(64'd1, 64'd0, 32'd16);
    send_block('1, '1, 32'd7);
    write_base('1);
    send_block('1, {{(DIG_W-1){1'b1}}, 1'b0}, 32'd2);
    send_block(64'd0, 64'd1, 32'd3);
    send_block({1'b1, {(DIG_W-1){1'b0}}}, {1'b1, {(DIG_W-1){1'b0}}}, '1);
    write_base('0);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 32'd100);
    write_base(32'h8000_0000);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 32'h8000_0000);
    send_block('0, '1, 32'd0);
    send_block('1, '0, 32'd1);

    bases[0] = 32'h8000_0000;
    bases[1] = 32'hFFFF_FFF0;
    bases[2] = $urandom;
    bases[3] = '0;
    bases[4] = '1;
    bases[5] = $urandom;
    prev_hi = '0;
    prev_lo = '0;

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n != 0 && n % PHASE_ITEMS == 0) write_base(bases[(n / PHASE_ITEMS) % 6]);

      used = tracker.known_hi.size();
      pick = $urandom_range(0, 99);
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if (pick < 3 && used != 0) begin
        // near miss: one bit away from a stored digest
        idx = $urandom_range(0, used - 1);
        hi = tracker.known_hi[idx];
        lo = tracker.known_lo[idx];
        if ($urandom_range(0, 1)) begin
          idx = $urandom_range(0, DIG_W - 1);
          hi[idx] = ~hi[idx];
        end else begin
          idx = $urandom_range(0, DIG_W - 1);
          lo[idx] = ~lo[idx];
        end
      end else if (pick < 6) begin
        // fresh random digest, already drawn
      end else if (pick < 9) begin
        case ($urandom_range(0, 3))
          0: hi = '0;
          1: lo = '0;
          2: hi = '1;
          default: lo = '1;
        endcase
      end else if (pick < 25) begin
        hi = prev_hi;
        lo = prev_lo;
      end else if (used != 0) begin
        if (pick < 30) idx = 0;
        else if (pick < 35) idx = used - 1;
        else idx = $urandom_range(0, used - 1);
        hi = tracker.known_hi[idx];
        lo = tracker.known_lo[idx];
      end

      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = '1;
        2, 3: len = $urandom_range(0, 255);
        default: len = $urandom;
      endcase

      quiet = (n >= 400 && n < 620);
      // idle gaps scale with TABLE_DEPTH, as does an item's time through the cell chain
      if (!quiet && $urandom_range(0, 99) < 11) begin
        idle_for($urandom_range(1, 2 * TABLE_DEPTH + 16));
      end
      send_block(hi, lo, len);
      prev_hi = hi;
      prev_lo = lo;
    end

    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("digest_dedup_offset_table_test passed");
    end else begin
      $display("digest_dedup_offset_table_test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("digest_dedup_offset_table_test failed");
    $finish;
  end

endmodule

FILE: files.f
sv/ddot_pkg.sv
sv/ddot_cell.sv
sv/digest_dedup_offset_table.sv
dv/digest_dedup_offset_table_test.sv
